>>> hw/rtl/slcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slcr_pkg;

  localparam logic [7:0] START_BYTE = 8'h02;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;
  localparam logic [1:0] KIND_DROP = 2'd3;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_POLY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR    = 2'd2;

  localparam logic [15:0] POLY_RESET    = 16'h8005;
  localparam logic [15:0] MAX_LEN_RESET = 16'd812;
  localparam logic [7:0]  ADDR_RESET    = 8'h80;

  typedef struct packed {
    logic [15:0] poly;
    logic [15:0] max_len;
    logic [7:0]  addr;
  } cfg_t;

  // one shift/xor step; the previous covered byte rides in the upper half
  function automatic logic [15:0] crc_step(input logic [15:0] crc,
                                           input logic [15:0] poly,
                                           input logic [7:0]  prev,
                                           input logic [7:0]  b);
    logic [15:0] c;
    begin
      c = {crc[14:0], 1'b0};
      if (crc[15]) begin
        c = c ^ poly;
      end
      crc_step = c ^ {prev, b};
    end
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/slcr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module slcr_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [slcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data,
  output slcr_pkg::cfg_t                      cfg
);
  import slcr_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.poly    <= POLY_RESET;
      regs.max_len <= MAX_LEN_RESET;
      regs.addr    <= ADDR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLY:    regs.poly    <= cfg_data;
        CFG_MAX_LEN: regs.max_len <= cfg_data;
        CFG_ADDR:    regs.addr    <= cfg_data[7:0];
        default:     ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

>>> hw/rtl/slcr_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module slcr_parser (
  input  wire logic           clk,
  input  wire logic           rst,
  input  slcr_pkg::cfg_t      cfg,
  input  wire logic           byte_valid,
  input  wire logic [7:0]     byte_in,
  output logic                advance,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_byte,
  output logic                frame_last,
  output logic [15:0]         frame_length,
  output logic [15:0]         computed_crc,
  output logic [15:0]         received_crc
);
  import slcr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC_LO  = 3'd4,
    PH_CRC_HI  = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  last_seen, last_seen_next;
  logic [15:0] plen, plen_next;
  logic [15:0] remaining, remaining_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  prev, prev_next;
  logic [7:0]  trail_lo, trail_lo_next;

  logic        emit;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] len_word;
  logic [15:0] crc_taken;
  logic [15:0] crc_sync;
  logic [15:0] recv_word;
  logic        take;

  assign advance = !out_valid || !out_stall;
  assign take    = byte_valid && advance;

  assign crc_taken = crc_step(crc, cfg.poly, prev, byte_in);
  // start byte taken from a zero crc, then the address byte
  assign crc_sync  = crc_step(crc_step(16'h0000, cfg.poly, 8'h00, START_BYTE),
                              cfg.poly, START_BYTE, byte_in);
  assign len_word  = {byte_in, plen[7:0]};
  assign recv_word = {byte_in, trail_lo};

  always_comb begin
    phase_next     = phase;
    last_seen_next = last_seen;
    plen_next      = plen;
    remaining_next = remaining;
    crc_next       = crc;
    prev_next      = prev;
    trail_lo_next  = trail_lo;
    emit           = 1'b0;
    kind           = KIND_DATA;
    data_byte      = 8'h00;
    unique case (phase)
      PH_LEN_LO: begin
        crc_next   = crc_taken;
        prev_next  = byte_in;
        plen_next  = {8'h00, byte_in};
        phase_next = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        crc_next  = crc_taken;
        prev_next = byte_in;
        plen_next = len_word;
        if (len_word > cfg.max_len) begin
          emit           = 1'b1;
          kind           = KIND_DROP;
          phase_next     = PH_HUNT;
          last_seen_next = 8'h00;
        end else begin
          remaining_next = len_word;
          phase_next     = (len_word == 16'h0000) ? PH_CRC_LO : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_next       = crc_taken;
        prev_next      = byte_in;
        remaining_next = remaining - 16'd1;
        if (remaining == 16'd1) begin
          phase_next = PH_CRC_LO;
        end
        emit      = 1'b1;
        kind      = KIND_DATA;
        data_byte = byte_in;
      end
      PH_CRC_LO: begin
        trail_lo_next = byte_in;
        phase_next    = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        emit           = 1'b1;
        kind           = (recv_word == crc) ? KIND_GOOD : KIND_BAD;
        phase_next     = PH_HUNT;
        last_seen_next = 8'h00;
      end
      default: begin
        if (last_seen == START_BYTE && byte_in == cfg.addr) begin
          crc_next       = crc_sync;
          prev_next      = byte_in;
          plen_next      = 16'h0000;
          remaining_next = 16'h0000;
          phase_next     = PH_LEN_LO;
        end else begin
          phase_next = PH_HUNT;
        end
        last_seen_next = byte_in;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      last_seen <= 8'h00;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase     <= phase_next;
        last_seen <= last_seen_next;
      end
      if (advance) begin
        out_valid <= take && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      plen      <= plen_next;
      remaining <= remaining_next;
      crc       <= crc_next;
      prev      <= prev_next;
      trail_lo  <= trail_lo_next;
    end
    if (take && emit) begin
      out_kind     <= kind;
      out_byte     <= data_byte;
      frame_last   <= (kind != KIND_DATA);
      frame_length <= plen_next;
      computed_crc <= (kind == KIND_GOOD || kind == KIND_BAD) ? crc : 16'h0000;
      received_crc <= (kind == KIND_GOOD || kind == KIND_BAD) ? recv_word : 16'h0000;
    end
  end

  a_end_to_hunt: assert property (@(posedge clk) disable iff (rst)
    (take && emit && kind != KIND_DATA) |=> (phase == PH_HUNT && last_seen == 8'h00))
    else $error("frame end did not return to hunting");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (remaining != 16'h0000))
    else $error("payload phase with no bytes remaining");

  a_good_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_GOOD) |-> (computed_crc == received_crc))
    else $error("good frame with mismatched checksum");

  a_data_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_DATA) |-> (!frame_last && computed_crc == 16'h0000))
    else $error("payload beat carries status fields");

  a_drop_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_DROP) |-> (frame_length > 16'h0000))
    else $error("drop reported for empty length");

endmodule

`default_nettype wire

>>> hw/rtl/sync_length_frame_crc_receiver_top.sv
// Channel  Handshake           Payload
// in       in_valid/in_stall   rx_byte
// out      out_valid/out_stall out_kind out_byte frame_last frame_length
//                              computed_crc received_crc
// cfg      cfg_we              cfg_index cfg_data (0 poly, 1 max payload, 2 address)
//
// One byte per cycle unless out_stall holds the output; a result is registered in
// the cycle after the parser takes its byte: input register, parse/CRC, output register.
// rst is synchronous; hunting restarts and the registers return to 0x8005/812/0x80.
// in_stall rises only when the input register holds a beat and the output register
// is full and stalled.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_frame_crc_receiver_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          out_kind,
  output logic [7:0]                          out_byte,
  output logic                                frame_last,
  output logic [15:0]                         frame_length,
  output logic [15:0]                         computed_crc,
  output logic [15:0]                         received_crc,
  input  wire logic                           cfg_we,
  input  wire logic [slcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data
);
  import slcr_pkg::*;

  cfg_t       cfg;
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       advance;

  assign in_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_byte <= rx_byte;
    end
  end

  slcr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slcr_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .byte_valid   (hold_valid),
    .byte_in      (hold_byte),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .frame_last   (frame_last),
    .frame_length (frame_length),
    .computed_crc (computed_crc),
    .received_crc (received_crc)
  );

endmodule

`default_nettype wire
